// File: hw/rtl/rrss_pkg.sv
// Package for the round-robin slice scheduler: constants, request/result
// structs, function codes and sequencer states. No dependencies.
package rrss_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);
    localparam int BURST_W   = 16;
    localparam int QUANT_W   = 16;
    localparam int TIME_W    = 20;
    localparam int PIDX_W    = 4;

    localparam logic [TIME_W-1:0]  TIME_MAX      = {TIME_W{1'b1}};
    localparam logic [QUANT_W-1:0] QUANTUM_RESET = QUANT_W'(2);

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_STEP  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [BURST_W-1:0] burst_time;
    } req_t;

    typedef struct packed {
        logic [PIDX_W-1:0] process_index;
        logic [TIME_W-1:0] slice_end_time;
        logic              finished;
        logic [TIME_W-1:0] turnaround_time;
        logic [TIME_W-1:0] waiting_time;
        logic              all_done;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_SETTLE,
        ST_OUT
    } state_t;

endpackage

// File: hw/rtl/round_robin_slice_scheduler.sv
// Round-robin slice scheduler top level; uses rrss_pkg.
// Flow: load, clear and unknown requests are handled in idle and give no result.
// A step request goes scan, exec, settle, out, its scan visiting 1..MAX_PROCS
// entries one per cycle (no work left: all entries, then out; empty table: idle to out).
// Throughput: one request at a time; hold the result until taken, then the next
// request is taken the cycle after. Loads and clears go back to back.
// Reset (aresetn low, synchronous): empty table, clock and pointer zero,
// quantum 2. Table contents are not cleared.
module round_robin_slice_scheduler (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rrss_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output rrss_pkg::rsp_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [rrss_pkg::QUANT_W-1:0] cfg_data
);
    import rrss_pkg::*;

    // Process tables: one compare unit walks remaining_reg one entry a cycle.
    logic [BURST_W-1:0] burst_reg     [MAX_PROCS];
    logic [BURST_W-1:0] remaining_reg [MAX_PROCS];

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   next_ptr_reg, next_ptr_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;      // scan pointer, then the chosen index
    logic [CNT_W-1:0]   visited_reg, visited_next;
    logic [TIME_W-1:0]  time_reg, time_next;
    logic [QUANT_W-1:0] quantum_reg, quantum_next;
    logic               fin_reg, fin_next;
    rsp_t               rsp_reg, rsp_next;

    // table write ports
    logic               load_we;
    logic               rem_we;
    logic [BURST_W-1:0] rem_wdata;

    logic               s_fire;
    logic [BURST_W-1:0] rem_rd;
    logic [BURST_W-1:0] burst_rd;
    logic [QUANT_W-1:0] q_eff;
    logic               fits;
    logic [BURST_W-1:0] run_len;
    logic [TIME_W:0]    time_sum;
    logic [TIME_W-1:0]  time_sat;
    logic [CNT_W-1:0]   ptr_inc;
    logic               ptr_wrap;
    logic [TIME_W-1:0]  burst_ext;

    assign s_fire   = s_valid && s_ready;
    assign rem_rd   = remaining_reg[ptr_reg];
    assign burst_rd = burst_reg[ptr_reg];

    // Treat a zero quantum as one time unit.
    assign q_eff    = (quantum_reg == '0) ? QUANT_W'(1) : quantum_reg;
    assign fits     = (rem_rd <= q_eff);
    assign run_len  = fits ? rem_rd : q_eff;

    // Saturating clock advance: a carry out of the 20-bit clock means overflow.
    assign time_sum = {1'b0, time_reg} + (TIME_W+1)'(run_len);
    assign time_sat = time_sum[TIME_W] ? TIME_MAX : time_sum[TIME_W-1:0];

    // Cyclic successor of the pointer within the loaded processes.
    assign ptr_inc  = CNT_W'(ptr_reg) + CNT_W'(1);
    assign ptr_wrap = (ptr_inc >= count_reg);

    assign burst_ext = TIME_W'(burst_rd);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_data.func == FUNC_STEP)) begin
                    state_next = (count_reg == '0) ? ST_OUT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rem_rd != '0) begin
                    state_next = ST_EXEC;
                end else if ((visited_reg + CNT_W'(1)) == count_reg) begin
                    state_next = ST_OUT;
                end
            end
            ST_EXEC:   state_next = ST_SETTLE;
            ST_SETTLE: state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        cfg_ready = 1'b1;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_OUT:  m_valid = 1'b1;
            default: begin
                s_ready = 1'b0;
                m_valid = 1'b0;
            end
        endcase
    end

    assign m_data = rsp_reg;

    // Datapath
    always_comb begin
        count_next    = count_reg;
        next_ptr_next = next_ptr_reg;
        ptr_next      = ptr_reg;
        visited_next  = visited_reg;
        time_next     = time_reg;
        quantum_next  = quantum_reg;
        fin_next      = fin_reg;
        rsp_next      = rsp_reg;
        load_we       = 1'b0;
        rem_we        = 1'b0;
        rem_wdata     = '0;

        if (cfg_valid && cfg_ready) begin
            quantum_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_data.func)
                        FUNC_LOAD: begin
                            // drop loads once the table is full
                            if (count_reg < CNT_W'(MAX_PROCS)) begin
                                load_we    = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        FUNC_CLEAR: begin
                            count_next    = '0;
                            next_ptr_next = '0;
                            time_next     = '0;
                        end
                        FUNC_STEP: begin
                            rsp_next          = '0;
                            rsp_next.all_done = (count_reg == '0);
                            visited_next      = '0;
                            ptr_next          = (CNT_W'(next_ptr_reg) >= count_reg) ?
                                                '0 : next_ptr_reg;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (rem_rd == '0) begin
                    visited_next = visited_reg + CNT_W'(1);
                    ptr_next     = ptr_wrap ? '0 : ptr_inc[IDX_W-1:0];
                    if ((visited_reg + CNT_W'(1)) == count_reg) begin
                        rsp_next.all_done = 1'b1;
                    end
                end
            end
            ST_EXEC: begin
                // run one slice of the chosen process
                time_next = time_sat;
                fin_next  = fits;
                rem_we    = 1'b1;
                rem_wdata = fits ? '0 : (rem_rd - q_eff);
            end
            ST_SETTLE: begin
                rsp_next.process_index  = PIDX_W'(ptr_reg);
                rsp_next.slice_end_time = time_reg;
                rsp_next.finished       = fin_reg;
                rsp_next.all_done       = 1'b0;
                if (fin_reg) begin
                    rsp_next.turnaround_time = time_reg;
                    rsp_next.waiting_time    = (time_reg >= burst_ext) ?
                                               (time_reg - burst_ext) : '0;
                end else begin
                    rsp_next.turnaround_time = '0;
                    rsp_next.waiting_time    = '0;
                end
                next_ptr_next = ptr_wrap ? '0 : ptr_inc[IDX_W-1:0];
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            next_ptr_reg <= '0;
            time_reg     <= '0;
            quantum_reg  <= QUANTUM_RESET;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            next_ptr_reg <= next_ptr_next;
            time_reg     <= time_next;
            quantum_reg  <= quantum_next;
        end
    end

    // Payload and table registers, no reset
    always_ff @(posedge aclk) begin
        ptr_reg     <= ptr_next;
        visited_reg <= visited_next;
        fin_reg     <= fin_next;
        rsp_reg     <= rsp_next;
        if (load_we) begin
            burst_reg[count_reg[IDX_W-1:0]]     <= s_data.burst_time;
            remaining_reg[count_reg[IDX_W-1:0]] <= s_data.burst_time;
        end
        if (rem_we) begin
            remaining_reg[ptr_reg] <= rem_wdata;
        end
    end

endmodule

// File: hw/rtl/rrss_checker.sv
// Port-level checker for the round-robin slice scheduler; uses rrss_pkg.
// Bound to the top level by the bind statement at the end of this file.
module rrss_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input rrss_pkg::req_t s_data,
    input logic           m_valid,
    input logic           m_ready,
    input rrss_pkg::rsp_t m_data,
    input logic           cfg_valid,
    input logic           cfg_ready,
    input logic [rrss_pkg::QUANT_W-1:0] cfg_data
);
    import rrss_pkg::*;

    // Hold a stalled result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    // Take no request while a result waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request taken while result pending");

    // An all-done result carries no slice.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.all_done |-> !m_data.finished &&
        m_data.slice_end_time == '0 && m_data.process_index == '0)
        else $error("all-done result carries slice data");

    // Times appear only for a finished process, and agree with the slice end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.finished |->
        m_data.turnaround_time == '0 && m_data.waiting_time == '0)
        else $error("times reported for unfinished process");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.finished |->
        m_data.turnaround_time == m_data.slice_end_time &&
        m_data.waiting_time <= m_data.turnaround_time)
        else $error("inconsistent completion times");

endmodule

bind round_robin_slice_scheduler rrss_checker u_rrss_checker (.*);

// File: sim/tb_round_robin_slice_scheduler.sv
// Self-checking testbench for round_robin_slice_scheduler: a directed part, then
// random workloads under several quantum settings, with random stalls on both sides.
// Depends on rrss_pkg and the scheduler RTL only.
module tb_round_robin_slice_scheduler;
    import rrss_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 3 + MAX_PROCS + 8;  // longest step latency plus margin
    localparam int RX_HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int CHUNK_ITEMS    = 235;                // six chunks, about 1550 requests
    localparam int STEP_CAP       = 60;

    // Clock, reset and DUT ports. Give every input a known value from time zero.
    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    req_t                s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    rsp_t                m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [QUANT_W-1:0]  cfg_data  = '0;

    // Stimulus side: requests waiting for the driver, idle rates, hold requests.
    req_t                request_queue[$];
    int                  tx_idle_pct   = 0;
    int                  rx_idle_pct   = 0;
    int                  hold_asked    = 0;
    int                  hold_served   = 0;
    int                  rx_hold_left  = 0;
    bit                  s_fire        = 1'b0;
    logic [QUANT_W-1:0]  gen_quantum   = QUANTUM_RESET;
    int                  queued_count  = 0;

    // Checking side: the scheduler's expected slice reports and the mirrored state.
    rsp_t                expected_slices[$];
    int                  fail_count    = 0;
    int                  cycle_count   = 0;
    logic [QUANT_W-1:0]  quantum;
    logic [BURST_W-1:0]  burst_tab [MAX_PROCS];
    logic [BURST_W-1:0]  rem_tab   [MAX_PROCS];
    logic [CNT_W-1:0]    proc_cnt;
    logic [IDX_W-1:0]    next_ptr;
    logic [TIME_W-1:0]   cur_time;

    round_robin_slice_scheduler DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // Advance the mirrored scheduler by one accepted request. Return 1 and fill
    // the slice report when the request produces a result (steps only).
    function automatic bit schedule_slice(input req_t req, output rsp_t slice);
        int                 sel;
        int                 c;
        int                 k;
        logic [QUANT_W-1:0] q;
        logic [TIME_W:0]    sum;
        slice = '0;
        sel   = -1;
        case (req.func)
            FUNC_LOAD: begin
                // Drop loads once the table is full.
                if (proc_cnt < MAX_PROCS) begin
                    burst_tab[proc_cnt[IDX_W-1:0]] = req.burst_time;
                    rem_tab[proc_cnt[IDX_W-1:0]]   = req.burst_time;
                    proc_cnt                       = proc_cnt + CNT_W'(1);
                end
                return 1'b0;
            end
            FUNC_CLEAR: begin
                proc_cnt = '0;
                next_ptr = '0;
                cur_time = '0;
                return 1'b0;
            end
            FUNC_STEP: begin
                if (next_ptr >= proc_cnt) next_ptr = '0;
                // Scan cyclically from the pointer; zero-burst and finished
                // entries are skipped.
                for (k = 0; k < proc_cnt; k++) begin
                    c = next_ptr + k;
                    if (c >= proc_cnt) c -= proc_cnt;
                    if (sel < 0 && rem_tab[c] != '0) sel = c;
                end
                if (sel < 0) begin
                    // No work left: report all_done, leave the clock alone.
                    slice.all_done = 1'b1;
                    return 1'b1;
                end
                q = (quantum == '0) ? QUANT_W'(1) : quantum;
                if (rem_tab[sel] <= q) begin
                    sum            = cur_time + rem_tab[sel];
                    rem_tab[sel]   = '0;
                    slice.finished = 1'b1;
                end else begin
                    sum          = cur_time + q;
                    rem_tab[sel] = rem_tab[sel] - q;
                end
                // Saturate the clock at its largest value.
                cur_time = (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
                if (slice.finished) begin
                    slice.turnaround_time = cur_time;
                    slice.waiting_time    = (cur_time >= burst_tab[sel]) ?
                                            cur_time - burst_tab[sel] : '0;
                end
                slice.process_index  = PIDX_W'(sel);
                slice.slice_end_time = cur_time;
                next_ptr = (sel + 1 >= proc_cnt) ? '0 : IDX_W'(sel + 1);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // Sample every handshake at the rising edge: mirror accepted requests and
    // quantum writes, compare each taken result with the oldest expectation.
    always @(posedge aclk) begin : monitor
        rsp_t predicted;
        rsp_t oldest;
        s_fire = s_valid && s_ready;
        if (!aresetn) begin
            quantum  = QUANTUM_RESET;
            proc_cnt = '0;
            next_ptr = '0;
            cur_time = '0;
        end else begin
            if (cfg_valid && cfg_ready) quantum = cfg_data;
            if (s_valid && s_ready) begin
                if (schedule_slice(s_data, predicted)) expected_slices.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                if (expected_slices.size() == 0) begin
                    $error("result with no expectation waiting: 0x%0h", m_data);
                    fail_count++;
                end else begin
                    oldest = expected_slices.pop_front();
                    check_field("process_index", 32'(oldest.process_index),
                                32'(m_data.process_index));
                    check_field("slice_end_time", 32'(oldest.slice_end_time),
                                32'(m_data.slice_end_time));
                    check_field("finished", 32'(oldest.finished),
                                32'(m_data.finished));
                    check_field("turnaround_time", 32'(oldest.turnaround_time),
                                32'(m_data.turnaround_time));
                    check_field("waiting_time", 32'(oldest.waiting_time),
                                32'(m_data.waiting_time));
                    check_field("all_done", 32'(oldest.all_done),
                                32'(m_data.all_done));
                end
            end
        end
    end

    // Request driver: hold valid and payload until taken, then advance to the
    // next queued request or idle at the current sender rate.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_data  <= request_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: stall at random, or hold off for a long stretch when asked.
    always @(negedge aclk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_served != hold_asked) begin
            hold_served  = hold_asked;
            rx_hold_left = RX_HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: end the run if the scheduler stops making progress.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_req(input func_t f, input logic [BURST_W-1:0] burst);
        req_t r;
        r.func       = f;
        r.burst_time = burst;
        request_queue.push_back(r);
        if (f != FUNC_NONE) queued_count++;
    endtask

    // Hold the stimulus until every request is taken and every result is back,
    // then let the last load or clear settle.
    task automatic wait_drained();
        while (request_queue.size() != 0 || s_valid || expected_slices.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_quantum(input logic [QUANT_W-1:0] value);
        @(negedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
        gen_quantum = value;
    endtask

    // One workload: usually a clear, a batch of loads (sometimes past full),
    // then enough steps to finish most of it plus a few all_done probes.
    // Sprinkle noise requests of any function in between.
    task automatic add_workload();
        int              n_loads;
        int              n_steps;
        int              work;
        int              q;
        int              span;
        logic [BURST_W-1:0] b;
        q    = (gen_quantum == '0) ? 1 : int'(gen_quantum);
        span = 4 * ((q > 16) ? 16 : q);
        work = 0;
        if ($urandom_range(5) != 0) push_req(FUNC_CLEAR, BURST_W'($urandom));
        n_loads = $urandom_range(1, MAX_PROCS + 2);
        for (int i = 0; i < n_loads; i++) begin
            case ($urandom_range(9))
                0:       b = '0;
                1:       b = BURST_W'($urandom);
                default: b = (q >= 4096) ? BURST_W'($urandom) : BURST_W'($urandom_range(1, span));
            endcase
            push_req(FUNC_LOAD, b);
            if (i < MAX_PROCS) work += (int'(b) + q - 1) / q;
        end
        n_steps = ((work > STEP_CAP) ? STEP_CAP : work) + $urandom_range(0, 3);
        for (int i = 0; i < n_steps; i++) begin
            push_req(FUNC_STEP, BURST_W'($urandom));
            if ($urandom_range(19) == 0)
                push_req(func_t'($urandom_range(3)), BURST_W'($urandom));
        end
    endtask

    // A full table of near-maximal bursts: drive the clock toward its top bits.
    task automatic add_heavy_workload();
        push_req(FUNC_CLEAR, '0);
        for (int i = 0; i < MAX_PROCS; i++)
            push_req(FUNC_LOAD, BURST_W'($urandom_range(60000, 65535)));
        for (int i = 0; i < MAX_PROCS + 2; i++)
            push_req(FUNC_STEP, '0);
    endtask

    initial begin : stimulus
        int                 start_count;
        logic [QUANT_W-1:0] phase_q [3][2];
        phase_q[0][0] = QUANT_W'(3);
        phase_q[0][1] = '0;
        phase_q[1][0] = '1;
        phase_q[1][1] = QUANT_W'(1);
        phase_q[2][0] = QUANT_W'($urandom_range(4, 16));
        phase_q[2][1] = QUANTUM_RESET;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset quantum of 2.
        push_req(FUNC_STEP,  '0);        // empty table: all_done
        push_req(FUNC_NONE,  '1);        // unknown function: ignored
        push_req(FUNC_LOAD,  '0);        // zero burst: never scheduled
        push_req(FUNC_LOAD,  '1);        // largest burst
        push_req(FUNC_LOAD,  16'd1);     // finishes inside one slice
        push_req(FUNC_LOAD,  16'd3);     // needs two slices
        repeat (5) push_req(FUNC_STEP, '0);
        push_req(FUNC_CLEAR, '1);
        push_req(FUNC_STEP,  '0);        // empty after clear
        push_req(FUNC_LOAD,  16'd2);     // burst equal to the quantum
        push_req(FUNC_STEP,  '0);
        push_req(FUNC_STEP,  '0);        // only finished work left: all_done
        wait_drained();

        // Random part: three idle profiles, two quantum settings in each.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin tx_idle_pct = 30; rx_idle_pct = 77; end
                1:       begin tx_idle_pct = 77; rx_idle_pct = 30; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            for (int chunk = 0; chunk < 2; chunk++) begin
                write_quantum(phase_q[phase][chunk]);
                // Stall the receiver for a long stretch while requests keep coming.
                if (phase == 0 && chunk == 0) hold_asked++;
                start_count = queued_count;
                if (phase_q[phase][chunk] == '1) add_heavy_workload();
                while (queued_count - start_count < CHUNK_ITEMS) add_workload();
                wait_drained();
            end
        end

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
